// ===== rtl/mono_framebuffer_draw_engine_assert.svh =====
// assertion macros for the draw engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define MFD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MFD_ASSERT_IMP(label, clk, rst_n, a, c)
`define MFD_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// types, command codes and font table for the framebuffer draw engine
// ----------------------------------------------------------------------------
`default_nettype none
package mfd_pkg;
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_LINE  = 3'd2;
    localparam logic [2:0] CMD_CHAR  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic       pixel_on;
        logic [7:0] char_code;
        logic [1:0] glyph_scale;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ignored;
    } t_out;

    // glyph columns for a code, lowercase folded, unknown shown as '?'
    function automatic logic [39:0] glyph_cols(input logic [7:0] code);
        logic [7:0] c;
        logic [39:0] g;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
        case (c)
            8'h20: g = 40'h00_00_00_00_00;
            8'h2D: g = 40'h08_08_08_08_08;
            8'h2E: g = 40'h00_60_60_00_00;
            8'h2F: g = 40'h20_10_08_04_02;
            8'h3A: g = 40'h00_36_36_00_00;
            8'h30: g = 40'h3E_51_49_45_3E;
            8'h31: g = 40'h00_42_7F_40_00;
            8'h32: g = 40'h42_61_51_49_46;
            8'h33: g = 40'h21_41_45_4B_31;
            8'h34: g = 40'h18_14_12_7F_10;
            8'h35: g = 40'h27_45_45_45_39;
            8'h36: g = 40'h3C_4A_49_49_30;
            8'h37: g = 40'h01_71_09_05_03;
            8'h38: g = 40'h36_49_49_49_36;
            8'h39: g = 40'h06_49_49_29_1E;
            8'h41: g = 40'h7E_11_11_11_7E;
            8'h42: g = 40'h7F_49_49_49_36;
            8'h43: g = 40'h3E_41_41_41_22;
            8'h44: g = 40'h7F_41_41_22_1C;
            8'h45: g = 40'h7F_49_49_49_41;
            8'h46: g = 40'h7F_09_09_09_01;
            8'h47: g = 40'h3E_41_49_49_7A;
            8'h48: g = 40'h7F_08_08_08_7F;
            8'h49: g = 40'h00_41_7F_41_00;
            8'h4A: g = 40'h20_40_41_3F_01;
            8'h4B: g = 40'h7F_08_14_22_41;
            8'h4C: g = 40'h7F_40_40_40_40;
            8'h4D: g = 40'h7F_02_0C_02_7F;
            8'h4E: g = 40'h7F_04_08_10_7F;
            8'h4F: g = 40'h3E_41_41_41_3E;
            8'h50: g = 40'h7F_09_09_09_06;
            8'h51: g = 40'h3E_41_51_21_5E;
            8'h52: g = 40'h7F_09_19_29_46;
            8'h53: g = 40'h46_49_49_49_31;
            8'h54: g = 40'h01_01_7F_01_01;
            8'h55: g = 40'h3F_40_40_40_3F;
            8'h56: g = 40'h1F_20_40_20_1F;
            8'h57: g = 40'h3F_40_38_40_3F;
            8'h58: g = 40'h63_14_08_14_63;
            8'h59: g = 40'h07_08_70_08_07;
            8'h5A: g = 40'h61_51_49_45_43;
            default: g = 40'h02_01_51_09_06;
        endcase
        return g; // column 0 in bits 39:32
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front
// two-entry command queue between the input channel and the draw back end
// ----------------------------------------------------------------------------
`default_nettype none
module mfd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mfd_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mfd_pkg::t_in        o_data
);
    import mfd_pkg::*;

    t_in        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back
// sequencer that carries out one command on the frame store
// ----------------------------------------------------------------------------
`default_nettype none
module mfd_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mfd_pkg::t_in   i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mfd_pkg::t_out       o_data
);
    import mfd_pkg::*;

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = SCREEN_WIDTH * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_PIXA  = 4'd2; // address and mask
    localparam logic [3:0] S_PIXB  = 4'd3; // read issued
    localparam logic [3:0] S_PIXC  = 4'd4; // data back, write
    localparam logic [3:0] S_LSTEP = 4'd5;
    localparam logic [3:0] S_GSTEP = 4'd6;
    localparam logic [3:0] S_RDA   = 4'd7;
    localparam logic [3:0] S_RDB   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ret;            // state to go back to after a pixel
    logic [AW-1:0] r_clr;
    logic          r_post;           // clear pass ends with a result
    t_in           r_cmd;
    // line walker
    logic [7:0]         r_ax, r_ay, r_bx, r_by;
    logic signed [11:0] r_dx, r_dy, r_err;
    logic               r_sx, r_sy;
    // glyph walker
    logic [39:0] r_glyph;
    logic [2:0]  r_gc, r_gr;
    logic        r_ix, r_iy;
    // pixel op
    logic [7:0]    r_px, r_py;
    logic          r_on;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_mask;
    // memory
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    // result
    logic          r_ovalid;
    t_out          r_out;

    logic               w_in_screen;
    logic [AW-1:0]      w_addr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [7:0]         w_wdata;
    logic [7:0]         w_gcol;
    logic               w_gbit;
    logic               w_sc2;
    logic               w_glast;
    logic [7:0]         w_gx, w_gy;
    logic [7:0]         w_dx8, w_dy8;
    logic signed [11:0] w_e2;
    logic               w_step_x, w_step_y;
    logic               w_scale_ok;
    logic               w_out_free;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign w_out_free = !r_ovalid || i_ready;

    assign w_in_screen = ({1'b0, r_px} < 9'(SCREEN_WIDTH))
                      && ({1'b0, r_py} < 9'(SCREEN_HEIGHT));
    assign w_addr = AW'(32'(r_py[7:3]) * 32'(SCREEN_WIDTH) + 32'(r_px));

    assign w_we    = (r_state == S_CLR) || ((r_state == S_PIXC) && w_in_screen);
    assign w_waddr = (r_state == S_CLR) ? r_clr : r_addr;
    assign w_wdata = (r_state == S_CLR) ? 8'h00 :
                     (r_on ? (r_rdata | r_mask) : (r_rdata & ~r_mask));

    // glyph column select, column 0 in the top byte
    always_comb begin
        case (r_gc)
            3'd0:    w_gcol = r_glyph[39:32];
            3'd1:    w_gcol = r_glyph[31:24];
            3'd2:    w_gcol = r_glyph[23:16];
            3'd3:    w_gcol = r_glyph[15:8];
            default: w_gcol = r_glyph[7:0];
        endcase
    end

    assign w_sc2   = (r_cmd.glyph_scale == 2'd2);
    assign w_gbit  = w_gcol[r_gr];
    assign w_gx    = r_cmd.x_start + (w_sc2 ? {4'd0, r_gc, 1'b0} : {5'd0, r_gc})
                   + {7'd0, r_ix};
    assign w_gy    = r_cmd.y_start + (w_sc2 ? {4'd0, r_gr, 1'b0} : {5'd0, r_gr})
                   + {7'd0, r_iy};
    assign w_glast = (r_gc == 3'd4) && (r_gr == 3'd6) && (r_ix == w_sc2)
                  && (r_iy == w_sc2);

    assign w_dx8 = (i_cmd.x_end >= i_cmd.x_start) ? i_cmd.x_end - i_cmd.x_start
                                                  : i_cmd.x_start - i_cmd.x_end;
    assign w_dy8 = (i_cmd.y_end >= i_cmd.y_start) ? i_cmd.y_end - i_cmd.y_start
                                                  : i_cmd.y_start - i_cmd.y_end;
    assign w_e2     = r_err <<< 1;
    assign w_step_x = (w_e2 > -r_dy);
    assign w_step_y = (w_e2 < r_dx);

    assign w_scale_ok = (i_cmd.glyph_scale == 2'd1) || (i_cmd.glyph_scale == 2'd2);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[r_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                case (i_cmd.command)
                    CMD_CLEAR: n_state = S_CLR;
                    CMD_PIXEL: n_state = S_PIXA;
                    CMD_LINE:  n_state = S_LSTEP;
                    CMD_CHAR:  n_state = w_scale_ok ? S_GSTEP : S_DONE;
                    CMD_READ:  n_state = S_RDA;
                    default:   n_state = S_DONE;
                endcase
            end
            S_CLR: if (r_clr == AW'(DEPTH - 1)) begin
                n_state = r_post ? S_DONE : S_IDLE;
            end
            S_PIXA:  n_state = S_PIXB;
            S_PIXB:  n_state = S_PIXC;
            S_PIXC:  n_state = r_ret;
            S_LSTEP: n_state = S_PIXA;
            S_GSTEP: begin
                if (w_gbit) n_state = S_PIXA;
                else if (w_glast) n_state = S_DONE;
            end
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;   // clearing pass over the store after reset
            r_clr    <= '0;
            r_post   <= 1'b0;    // reset pass does not post a result
            r_ovalid <= 1'b0;
            r_ret    <= S_DONE;
            r_out    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd   <= i_cmd;
                    r_clr   <= '0;
                    r_post  <= 1'b1;
                    r_px    <= i_cmd.x_start;
                    r_py    <= i_cmd.y_start;
                    r_on    <= i_cmd.pixel_on;
                    r_ret   <= S_DONE;
                    r_ax    <= i_cmd.x_start;
                    r_ay    <= i_cmd.y_start;
                    r_bx    <= i_cmd.x_end;
                    r_by    <= i_cmd.y_end;
                    r_dx    <= {4'd0, w_dx8};
                    r_dy    <= {4'd0, w_dy8};
                    r_err   <= {4'd0, w_dx8} - {4'd0, w_dy8};
                    r_sx    <= i_cmd.x_start < i_cmd.x_end;
                    r_sy    <= i_cmd.y_start < i_cmd.y_end;
                    r_glyph <= glyph_cols(i_cmd.char_code);
                    r_gc    <= '0;
                    r_gr    <= '0;
                    r_ix    <= 1'b0;
                    r_iy    <= 1'b0;
                end
                S_CLR: r_clr <= r_clr + 1'b1;
                S_PIXA: begin
                    r_addr <= w_addr;
                    r_mask <= 8'd1 << r_py[2:0];
                end
                S_LSTEP: begin
                    // plot the current point, then take one Bresenham step
                    r_px  <= r_ax;
                    r_py  <= r_ay;
                    r_on  <= 1'b1;
                    r_ret <= (r_ax == r_bx && r_ay == r_by) ? S_DONE : S_LSTEP;
                    if (w_step_x) r_ax <= r_sx ? r_ax + 8'd1 : r_ax - 8'd1;
                    if (w_step_y) r_ay <= r_sy ? r_ay + 8'd1 : r_ay - 8'd1;
                    r_err <= r_err - (w_step_x ? r_dy : 12'sd0)
                                   + (w_step_y ? r_dx : 12'sd0);
                end
                S_GSTEP: begin
                    // advance iy, ix, row, column
                    if (r_iy != w_sc2) r_iy <= 1'b1;
                    else begin
                        r_iy <= 1'b0;
                        if (r_ix != w_sc2) r_ix <= 1'b1;
                        else begin
                            r_ix <= 1'b0;
                            if (r_gr != 3'd6) r_gr <= r_gr + 3'd1;
                            else begin
                                r_gr <= 3'd0;
                                r_gc <= r_gc + 3'd1;
                            end
                        end
                    end
                    if (w_gbit) begin
                        r_px  <= w_gx;
                        r_py  <= w_gy;
                        r_on  <= 1'b1;
                        r_ret <= w_glast ? S_DONE : S_GSTEP;
                    end
                end
                S_RDA: begin
                    r_addr <= AW'(32'(r_cmd.read_page) * 32'(SCREEN_WIDTH)
                                  + 32'(r_cmd.read_column));
                end
                S_DONE: if (w_out_free) begin
                    r_out.ignored <= (r_cmd.command == CMD_CHAR) &&
                        !(r_cmd.glyph_scale == 2'd1 || r_cmd.glyph_scale == 2'd2);
                    r_out.read_data <= ((r_cmd.command == CMD_READ)
                        && (32'(r_cmd.read_page) < 32'(PAGES))
                        && (32'(r_cmd.read_column) < 32'(SCREEN_WIDTH))) ? r_rdata : 8'h00;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// command-driven drawing engine over a page-organized monochrome store
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | input     | mfd_pkg::t_in  (i_in_valid / o_in_ready)
// out     | output    | mfd_pkg::t_out (o_out_valid / i_out_ready)
// sequence: clear writes zero to each store byte in turn; each drawn pixel is a
//   read-modify-write through the address, read and write states, after a step
//   state for line and glyph pixels
// reads and single pixels post their result from the done state
// reset: a clearing pass over all SCREEN_WIDTH*pages bytes runs after reset;
//   the queue takes up to two transactions meanwhile
// stalls: a result waits in an output register; the back end holds in its
//   done state while an earlier result is not taken, and the two-entry queue
//   keeps taking commands until it is full while the back end works
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_framebuffer_draw_engine_assert.svh"
module mono_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mfd_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mfd_pkg::t_out       o_out_data
);
    import mfd_pkg::*;

    logic q_valid, q_ready;
    t_in  q_data;

    // front queue decouples command intake from drawing
    mfd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(i_in_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    // back end sequences the store accesses
    mfd_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_data),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(o_out_data)
    );

    // a result never shows an ignored flag together with read data
    `MFD_ASSERT_IMP(a_ign_no_data, i_clk, i_rst_n,
        o_out_valid && o_out_data.ignored, o_out_data.read_data == 8'h00)
    // a stalled result stays put until taken
    `MFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // a queued command stays put until the back end takes it
    `MFD_ASSERT_NXT(a_q_hold, i_clk, i_rst_n,
        q_valid && !q_ready, q_valid && $stable(q_data))
endmodule
`default_nettype wire

// ===== bench/draw_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_engine_checker
// shadows the pixel store, predicts each result and compares it
// ----------------------------------------------------------------------------
module draw_engine_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  mfd_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  mfd_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);
    import mfd_pkg::*;

    localparam int WIDTH  = 128;
    localparam int HEIGHT = 64;
    localparam int PAGES  = (HEIGHT + 7) / 8;

    logic [7:0] shadow [WIDTH*PAGES];
    t_out expected_q [$];

    function automatic logic [39:0] font_bits(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") c = c - 8'd32;
        case (c)
            " ": return 40'h00_00_00_00_00;
            "-": return 40'h08_08_08_08_08;
            ".": return 40'h00_60_60_00_00;
            "/": return 40'h20_10_08_04_02;
            ":": return 40'h00_36_36_00_00;
            "0": return 40'h3E_51_49_45_3E;
            "1": return 40'h00_42_7F_40_00;
            "2": return 40'h42_61_51_49_46;
            "3": return 40'h21_41_45_4B_31;
            "4": return 40'h18_14_12_7F_10;
            "5": return 40'h27_45_45_45_39;
            "6": return 40'h3C_4A_49_49_30;
            "7": return 40'h01_71_09_05_03;
            "8": return 40'h36_49_49_49_36;
            "9": return 40'h06_49_49_29_1E;
            "A": return 40'h7E_11_11_11_7E;
            "B": return 40'h7F_49_49_49_36;
            "C": return 40'h3E_41_41_41_22;
            "D": return 40'h7F_41_41_22_1C;
            "E": return 40'h7F_49_49_49_41;
            "F": return 40'h7F_09_09_09_01;
            "G": return 40'h3E_41_49_49_7A;
            "H": return 40'h7F_08_08_08_7F;
            "I": return 40'h00_41_7F_41_00;
            "J": return 40'h20_40_41_3F_01;
            "K": return 40'h7F_08_14_22_41;
            "L": return 40'h7F_40_40_40_40;
            "M": return 40'h7F_02_0C_02_7F;
            "N": return 40'h7F_04_08_10_7F;
            "O": return 40'h3E_41_41_41_3E;
            "P": return 40'h7F_09_09_09_06;
            "Q": return 40'h3E_41_51_21_5E;
            "R": return 40'h7F_09_19_29_46;
            "S": return 40'h46_49_49_49_31;
            "T": return 40'h01_01_7F_01_01;
            "U": return 40'h3F_40_40_40_3F;
            "V": return 40'h1F_20_40_20_1F;
            "W": return 40'h3F_40_38_40_3F;
            "X": return 40'h63_14_08_14_63;
            "Y": return 40'h07_08_70_08_07;
            "Z": return 40'h61_51_49_45_43;
            default: return 40'h02_01_51_09_06;
        endcase
    endfunction

    function automatic void plot(input int px, input int py, input bit on);
        int idx;
        if (px >= WIDTH || py >= HEIGHT) return;
        idx = (py / 8) * WIDTH + px;
        if (on) shadow[idx][py % 8] = 1'b1;
        else    shadow[idx][py % 8] = 1'b0;
    endfunction

    function automatic void trace_line(input int ax, input int ay, input int bx, input int by);
        int dx, dy, sx, sy, err, e2;
        dx = (bx >= ax) ? bx - ax : ax - bx;
        dy = (by >= ay) ? by - ay : ay - by;
        sx = (ax < bx) ? 1 : -1;
        sy = (ay < by) ? 1 : -1;
        err = dx - dy;
        forever begin
            plot(ax, ay, 1'b1);
            if (ax == bx && ay == by) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                ax += sx;
            end
            if (e2 < dx) begin
                err += dx;
                ay += sy;
            end
        end
    endfunction

    function automatic t_out apply_command(input t_in cmd);
        t_out res;
        logic [39:0] g;
        logic [7:0] column_bits;
        int sc;
        res = '0;
        case (cmd.command)
            CMD_CLEAR: foreach (shadow[i]) shadow[i] = 8'h00;
            CMD_PIXEL: plot(cmd.x_start, cmd.y_start, cmd.pixel_on);
            CMD_LINE:  trace_line(cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end);
            CMD_CHAR: begin
                sc = cmd.glyph_scale;
                if (sc == 1 || sc == 2) begin
                    g = font_bits(cmd.char_code);
                    for (int c = 0; c < 5; c++) begin
                        column_bits = g[39 - 8*c -: 8];
                        for (int r = 0; r < 7; r++) begin
                            if (column_bits[r])
                                for (int ix = 0; ix < sc; ix++)
                                    for (int iy = 0; iy < sc; iy++)
                                        plot((cmd.x_start + c*sc + ix) & 255,
                                             (cmd.y_start + r*sc + iy) & 255, 1'b1);
                        end
                    end
                end else begin
                    res.ignored = 1'b1;
                end
            end
            CMD_READ:
                if (cmd.read_page < PAGES && cmd.read_column < WIDTH)
                    res.read_data = shadow[cmd.read_page * WIDTH + cmd.read_column];
            default: ;
        endcase
        return res;
    endfunction

    initial foreach (shadow[i]) shadow[i] = 8'h00;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_q.push_back(apply_command(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.read_data !== i_out_data.read_data) begin
                        $display("%0t: read_data expected %h actual %h", $time,
                                 want.read_data, i_out_data.read_data);
                        o_errors <= o_errors + 1;
                    end else if (want.ignored !== i_out_data.ignored) begin
                        $display("%0t: ignored expected %b actual %b", $time,
                                 want.ignored, i_out_data.ignored);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// directed and random drawing commands with bursty input and stalled output
// ----------------------------------------------------------------------------
module testbench;
    import mfd_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int IN_W         = $bits(t_in);

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    t_in   in_data;
    logic  out_valid;
    logic  out_ready;
    t_out  out_data;
    int    errors;
    int    pending;
    int    cycles = 0;
    bit    long_hold;   // receiver holds off for a long stretch when set

    mono_framebuffer_draw_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    draw_engine_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    initial begin
        rst_n = 1'b0;
    end

    // watchdog on total cycles
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (long_hold) out_ready <= 1'b0;
        else if (cycles[9]) out_ready <= 1'b1;          // stretches with no stall
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        long_hold = 1'b0;
        wait (cycles > 20000);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (6000) @(posedge clk);
        long_hold <= 1'b0;
    end

    // send one transaction: hold valid until accepted
    task automatic send(input t_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // random bits everywhere, then the used fields shaped
    function automatic t_in random_item();
        t_in it;
        int pick;
        it = IN_W'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 2)       it.command = CMD_CLEAR;
        else if (pick < 25) it.command = CMD_PIXEL;
        else if (pick < 40) it.command = CMD_LINE;
        else if (pick < 55) it.command = CMD_CHAR;
        else if (pick < 95) it.command = CMD_READ;
        else                it.command = 3'($urandom_range(5, 7));
        // mostly short lines on the screen, sometimes off it
        if ($urandom_range(0, 3) != 0) begin
            it.x_start = 8'($urandom_range(0, 127));
            it.y_start = 8'($urandom_range(0, 63));
            it.x_end = 8'(it.x_start + $urandom_range(0, 40) - 20);
            it.y_end = 8'(it.y_start + $urandom_range(0, 40) - 20);
        end
        if (it.command == CMD_CHAR && $urandom_range(0, 5) != 0)
            it.glyph_scale = 2'($urandom_range(1, 2));
        if (it.command == CMD_CHAR && $urandom_range(0, 1) != 0)
            it.char_code = 8'($urandom_range(8'h20, 8'h7A));
        return it;
    endfunction

    initial begin
        t_in item;
        int gap;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        item = '0;
        item.command = CMD_READ; send(item);
        item.command = CMD_PIXEL; item.pixel_on = 1'b1;
        item.x_start = 0; item.y_start = 0; send(item);
        item.x_start = 127; item.y_start = 63; send(item);
        item.x_start = 128; item.y_start = 5; send(item);    // clipped
        item.x_start = 255; item.y_start = 255; send(item);  // clipped
        item.command = CMD_READ; item.read_page = 7; item.read_column = 127; send(item);
        item.read_page = 0; item.read_column = 0; send(item);
        item.command = CMD_PIXEL; item.pixel_on = 1'b0;
        item.x_start = 0; item.y_start = 0; send(item);
        item.command = CMD_LINE;
        item.x_start = 0; item.y_start = 0; item.x_end = 255; item.y_end = 255; send(item);
        item.x_start = 120; item.y_start = 60; item.x_end = 3; item.y_end = 2; send(item);
        item.x_start = 10; item.y_start = 10; item.x_end = 10; item.y_end = 10; send(item);
        item.command = CMD_CHAR; item.x_start = 250; item.y_start = 252;
        item.char_code = "a"; item.glyph_scale = 2; send(item);   // wraps
        item.char_code = 8'hFF; item.glyph_scale = 1; item.x_start = 40; send(item);
        item.char_code = "Z"; item.glyph_scale = 0; send(item);
        item.glyph_scale = 3; send(item);
        item.command = CMD_READ; item.read_page = 0; item.read_column = 40; send(item);
        item.read_page = 0; item.read_column = 2; send(item);
        item.command = 3'd5; send(item);
        item.command = 3'd7; send(item);
        item.command = CMD_CLEAR; send(item);
        item.command = CMD_READ; item.read_page = 1; item.read_column = 10; send(item);

        // random part in bursts
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            for (int b = $urandom_range(1, 12); b > 0 && n < RANDOM_ITEMS; b--, n++)
                send(random_item());
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (errors == 0 && pending == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mfd_pkg.sv
rtl/mfd_front.sv
rtl/mfd_back.sv
rtl/mono_framebuffer_draw_engine.sv
bench/draw_engine_checker.sv
bench/testbench.sv
